// ----- design/bnt_pkg.sv -----
// Shared types and constants for the decision-diagram unique node table.
// Holds field widths, the FNV-1a constants and the result status codes.
// Depends on nothing else.
package bnt_pkg;

  localparam int VAR_W  = 8;
  localparam int IDX_W  = 10;
  localparam int HASH_W = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c_9dc5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NEW     = 2'd1,
    ST_REDUCED = 2'd2,
    ST_FULL    = 2'd3
  } bnt_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bnt_hash_stat_t;

endpackage

// ----- design/bnt_hash.sv -----
// Iterative FNV-1a hash over three zero-extended words with one shared multiplier.
// One multiply per cycle for each of the three words, then a one-cycle done pulse.
// Depends on bnt_pkg.
module bnt_hash import bnt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [VAR_W-1:0]    var_in,
  input  logic [IDX_W-1:0]    high_in,
  input  logic [IDX_W-1:0]    low_in,
  output bnt_hash_stat_t      stat,
  output logic [HASH_W-1:0]   hash
);

  logic [HASH_W-1:0] x_r;
  logic [1:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [HASH_W-1:0] prod;

  assign prod = x_r * FNV_PRIME;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        case (cnt_r)
          2'd0: begin
            cnt_r <= 2'd1;
          end
          2'd1: begin
            cnt_r <= 2'd2;
          end
          default: begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
            cnt_r  <= 2'd0;
          end
        endcase
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= FNV_BASIS ^ HASH_W'(var_in);
    end else if (busy_r) begin
      case (cnt_r)
        2'd0:    x_r <= prod ^ HASH_W'(high_in);
        2'd1:    x_r <= prod ^ HASH_W'(low_in);
        default: x_r <= prod;
      endcase
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign hash      = x_r;

endmodule

// ----- design/bnt_ram.sv -----
// Simple dual-port memory: one write port and one registered read port.
// Used for the bucket heads and for the node entries.
// Depends on nothing else.
module bnt_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/bdd_unique_node_table_unit.sv -----
// Unique node table: after reset the bucket heads are cleared one per cycle, with in_stall
// high. A request with equal children goes straight from S_IDLE to S_DONE as a reduced
// result. Any other request makes three passes through the shared 32-bit hash multiplier,
// then walks its bucket chain, where each chain entry costs one node memory read in S_WALK
// plus one compare in S_CMP, and ends found, new or full. One request is handled at a time;
// a finished result may wait in the output register while the next request is taken.
module bdd_unique_node_table_unit import bnt_pkg::*; #(
  parameter int MAX_NODES    = 1024,
  parameter int BUCKET_COUNT = 2048
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [VAR_W-1:0] in_var_number,
  input  logic [IDX_W-1:0] in_high_child,
  input  logic [IDX_W-1:0] in_low_child,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IDX_W-1:0] out_node_index,
  output logic [1:0]       out_status
);

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int LINK_W  = NODE_W + 1;
  localparam int BKT_W   = $clog2(BUCKET_COUNT);
  localparam int ENTRY_W = VAR_W + 2 * IDX_W + LINK_W;
  localparam int NXT_LO  = 0;
  localparam int LOW_LO  = LINK_W;
  localparam int HIGH_LO = LINK_W + IDX_W;
  localparam int VAR_LO  = LINK_W + 2 * IDX_W;

  localparam logic [LINK_W-1:0] NULL_LINK = '1;
  localparam logic [LINK_W-1:0] MAX_L     = LINK_W'(MAX_NODES);
  localparam logic [BKT_W-1:0]  BKT_LAST  = BKT_W'(BUCKET_COUNT - 1);
  localparam logic [HASH_W-1:0] BKT_MASK  = HASH_W'(BUCKET_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD_WAIT,
    S_WALK,
    S_CMP,
    S_INSERT,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [VAR_W-1:0]  var_r;
  logic [IDX_W-1:0]  high_r;
  logic [IDX_W-1:0]  low_r;
  logic [BKT_W-1:0]  bkt_r;
  logic [BKT_W-1:0]  clr_cnt_r;
  logic [LINK_W-1:0] head_r;
  logic [LINK_W-1:0] cur_r;
  logic [LINK_W-1:0] steps_r;
  logic [LINK_W-1:0] nodes_used_r;
  logic [IDX_W-1:0]  res_index_r;
  bnt_status_t       res_status_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_node_index_r;
  bnt_status_t       out_status_r;

  bnt_hash_stat_t    hash_stat;
  logic [HASH_W-1:0] hash;
  logic              hash_start;

  logic              bkt_we;
  logic [BKT_W-1:0]  bkt_waddr;
  logic [LINK_W-1:0] bkt_wdata;
  logic              bkt_re;
  logic [BKT_W-1:0]  bkt_raddr;
  logic [LINK_W-1:0] bkt_rdata;

  logic               node_we;
  logic               node_re;
  logic [ENTRY_W-1:0] node_wdata;
  logic [ENTRY_W-1:0] node_rdata;

  logic full;
  logic walk_ok;
  logic match;

  assign full    = (nodes_used_r >= MAX_L);
  assign walk_ok = (cur_r < MAX_L) && (steps_r < MAX_L);
  assign match   = (node_rdata[VAR_LO +: VAR_W] == var_r) &&
                   (node_rdata[HIGH_LO +: IDX_W] == high_r) &&
                   (node_rdata[LOW_LO +: IDX_W] == low_r);

  assign hash_start = (state_r == S_IDLE) && in_valid && (in_high_child != in_low_child);
  assign bkt_raddr  = BKT_W'(hash & BKT_MASK);
  assign bkt_re     = (state_r == S_HASH) && hash_stat.done;
  assign node_re    = (state_r == S_WALK) && walk_ok;
  assign node_we    = (state_r == S_INSERT) && !full;
  assign node_wdata = {var_r, high_r, low_r, head_r};

  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = clr_cnt_r;
    bkt_wdata = NULL_LINK;
    if (state_r == S_CLEAR) begin
      bkt_we = 1'b1;
    end else if (node_we) begin
      bkt_we    = 1'b1;
      bkt_waddr = bkt_r;
      bkt_wdata = nodes_used_r;
    end
  end

  bnt_hash u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .var_in  (in_var_number),
    .high_in (high_r),
    .low_in  (low_r),
    .stat    (hash_stat),
    .hash    (hash)
  );

  bnt_ram #(
    .DEPTH (BUCKET_COUNT),
    .WIDTH (LINK_W)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .re    (bkt_re),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  bnt_ram #(
    .DEPTH (MAX_NODES),
    .WIDTH (ENTRY_W)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (nodes_used_r[NODE_W-1:0]),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (cur_r[NODE_W-1:0]),
    .rdata (node_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      nodes_used_r <= LINK_W'(2);
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == BKT_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            var_r  <= in_var_number;
            high_r <= in_high_child;
            low_r  <= in_low_child;
            if (in_high_child == in_low_child) begin
              res_index_r  <= in_high_child;
              res_status_r <= ST_REDUCED;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_stat.done) begin
            bkt_r   <= bkt_raddr;
            state_r <= S_HEAD_WAIT;
          end
        end
        S_HEAD_WAIT: begin
          head_r  <= bkt_rdata;
          cur_r   <= bkt_rdata;
          steps_r <= '0;
          state_r <= S_WALK;
        end
        S_WALK: begin
          state_r <= walk_ok ? S_CMP : S_INSERT;
        end
        S_CMP: begin
          if (match) begin
            res_index_r  <= IDX_W'(cur_r);
            res_status_r <= ST_FOUND;
            state_r      <= S_DONE;
          end else begin
            cur_r   <= node_rdata[NXT_LO +: LINK_W];
            steps_r <= steps_r + 1'b1;
            state_r <= S_WALK;
          end
        end
        S_INSERT: begin
          if (full) begin
            res_index_r  <= '0;
            res_status_r <= ST_FULL;
          end else begin
            res_index_r  <= IDX_W'(nodes_used_r);
            res_status_r <= ST_NEW;
            nodes_used_r <= nodes_used_r + 1'b1;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r      <= 1'b1;
            out_node_index_r <= res_index_r;
            out_status_r     <= res_status_r;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_node_index = out_node_index_r;
  assign out_status     = out_status_r;

endmodule

// ----- design/bnt_checker.sv -----
// Port-level checks for the unique node table, bound to the top level.
// Watches both handshakes and the result codes. Depends on bnt_pkg.
module bnt_checker import bnt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [IDX_W-1:0] out_node_index,
  input logic [1:0]       out_status
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("Block not quiet after reset.");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Second request taken while the first is in progress.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_node_index) && $stable(out_status))
    else $error("Stalled result changed or was dropped.");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_node_index == '0)
    else $error("Full result carries a non-zero index.");

  a_no_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_FOUND) || (out_status == ST_NEW)) |->
      out_node_index > IDX_W'(1))
    else $error("Found or new result names a terminal node.");

endmodule

bind bdd_unique_node_table_unit bnt_checker u_bnt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_node_index (out_node_index),
  .out_status     (out_status)
);

// ----- sim/tb_bdd_unique_node_table_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the decision-diagram unique node table, with its own
// hash-consing predictor and random idling on both channels.
// Depends on bnt_pkg and bdd_unique_node_table_unit.
module tb_bdd_unique_node_table_unit;
  import bnt_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int BUCKETS     = 2048;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [10:0] NULL_LINK = 11'h7FF;

  typedef struct packed {
    logic [VAR_W-1:0] v;
    logic [IDX_W-1:0] h;
    logic [IDX_W-1:0] l;
  } node_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    bnt_status_t      st;
  } node_result_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [VAR_W-1:0] in_var_number = '0;
  logic [IDX_W-1:0] in_high_child = '0;
  logic [IDX_W-1:0] in_low_child = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] out_node_index;
  logic [1:0]       out_status;

  logic [VAR_W-1:0] node_var [TABLE_DEPTH];
  logic [IDX_W-1:0] node_hi [TABLE_DEPTH];
  logic [IDX_W-1:0] node_lo [TABLE_DEPTH];
  logic [10:0]      node_next [TABLE_DEPTH];
  logic [10:0]      bucket_head [BUCKETS];
  int               nodes_used;

  node_req_t    pending_requests[$];
  node_req_t    issued_reqs[$];
  node_result_t expected_nodes[$];

  int send_idle_pct = 6;
  int recv_stall_pct = 61;
  int error_count = 0;
  int cycle_count = 0;
  int accepted_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  bdd_unique_node_table_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_var_number (in_var_number),
    .in_high_child (in_high_child),
    .in_low_child  (in_low_child),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_node_index(out_node_index),
    .out_status    (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [10:0] node_bucket(input node_req_t r);
    logic [31:0] x;
    x = FNV_BASIS;
    x = (x ^ {24'd0, r.v}) * FNV_PRIME;
    x = (x ^ {22'd0, r.h}) * FNV_PRIME;
    x = (x ^ {22'd0, r.l}) * FNV_PRIME;
    return x[10:0];
  endfunction

  function automatic node_result_t predict_node_lookup(input node_req_t r);
    node_result_t res;
    logic [10:0]  b;
    logic [10:0]  cur;
    int           steps;
    logic         hit;
    if (r.h == r.l) begin
      res.idx = r.h;
      res.st  = ST_REDUCED;
      return res;
    end
    b = node_bucket(r);
    cur = bucket_head[b];
    steps = 0;
    hit = 1'b0;
    while (!hit && cur != NULL_LINK && cur < TABLE_DEPTH && steps < TABLE_DEPTH) begin
      if (node_var[cur[9:0]] == r.v && node_hi[cur[9:0]] == r.h && node_lo[cur[9:0]] == r.l) begin
        hit = 1'b1;
      end else begin
        cur = node_next[cur[9:0]];
        steps++;
      end
    end
    if (hit) begin
      res.idx = cur[9:0];
      res.st  = ST_FOUND;
    end else if (nodes_used >= TABLE_DEPTH) begin
      res.idx = '0;
      res.st  = ST_FULL;
    end else begin
      node_var[nodes_used]  = r.v;
      node_hi[nodes_used]   = r.h;
      node_lo[nodes_used]   = r.l;
      node_next[nodes_used] = bucket_head[b];
      bucket_head[b] = 11'(nodes_used);
      res.idx = IDX_W'(nodes_used);
      res.st  = ST_NEW;
      nodes_used++;
    end
    return res;
  endfunction

  function automatic node_req_t random_node_request();
    node_req_t r;
    int        pick;
    int        span;
    pick = $urandom_range(99);
    span = issued_reqs.size() + 2;
    if (span > 1023) span = 1023;
    if (pick < 30 && issued_reqs.size() > 0) begin
      r = issued_reqs[$urandom_range(issued_reqs.size() - 1)];
    end else if (pick < 40) begin
      r.v = VAR_W'($urandom);
      r.h = IDX_W'($urandom);
      r.l = r.h;
    end else if (pick < 88) begin
      r.v = VAR_W'($urandom_range(255));
      r.h = IDX_W'($urandom_range(span));
      r.l = IDX_W'($urandom_range(span));
    end else begin
      r.v = VAR_W'($urandom);
      r.h = IDX_W'($urandom);
      r.l = IDX_W'($urandom);
    end
    return r;
  endfunction

  task automatic post_request(input node_req_t r);
    pending_requests.push_back(r);
    issued_reqs.push_back(r);
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_nodes.size() != 0);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_nodes.size());
      $display("tb_bdd_unique_node_table_unit: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    node_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        r.v = in_var_number;
        r.h = in_high_child;
        r.l = in_low_child;
        expected_nodes.push_back(predict_node_lookup(r));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_requests.pop_front();
          in_valid      <= 1'b1;
          in_var_number <= r.v;
          in_high_child <= r.h;
          in_low_child  <= r.l;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    node_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_nodes.size() == 0) begin
          report_mismatch($sformatf("result index %0d status %0d with no request outstanding",
                                    out_node_index, out_status));
        end else begin
          e = expected_nodes.pop_front();
          status_seen[out_status]++;
          if (out_node_index !== e.idx)
            report_mismatch($sformatf("node index %0d, expected %0d", out_node_index, e.idx));
          if (out_status !== e.st)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, e.st));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    node_req_t base;
    node_req_t alt;
    node_req_t same_bucket[$];
    logic [10:0] want;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      node_var[i]  = '0;
      node_hi[i]   = '0;
      node_lo[i]   = '0;
      node_next[i] = '0;
    end
    for (int i = 0; i < BUCKETS; i++) bucket_head[i] = NULL_LINK;
    for (int i = 0; i < 2; i++) begin
      node_var[i]  = 8'hFF;
      node_next[i] = NULL_LINK;
    end
    nodes_used = 2;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    post_request('{v: 8'd0, h: 10'd0, l: 10'd0});
    post_request('{v: 8'd255, h: 10'd1023, l: 10'd1023});
    post_request('{v: 8'd0, h: 10'd1, l: 10'd1});
    post_request('{v: 8'd0, h: 10'd0, l: 10'd1});
    post_request('{v: 8'd0, h: 10'd1, l: 10'd0});
    post_request('{v: 8'd0, h: 10'd0, l: 10'd1});
    post_request('{v: 8'd255, h: 10'd1023, l: 10'd0});
    post_request('{v: 8'd255, h: 10'd0, l: 10'd1023});
    post_request('{v: 8'd128, h: 10'd1022, l: 10'd1023});
    post_request('{v: 8'd255, h: 10'd1023, l: 10'd0});
    post_request('{v: 8'd1, h: 10'd0, l: 10'd1});
    post_request('{v: 8'd2, h: 10'd0, l: 10'd1});

    // Three distinct nodes sharing one bucket exercise the chain walk.
    base = '{v: 8'd3, h: 10'd2, l: 10'd4};
    want = node_bucket(base);
    same_bucket.push_back(base);
    while (same_bucket.size() < 3) begin
      alt.v = VAR_W'($urandom);
      alt.h = IDX_W'($urandom);
      alt.l = IDX_W'($urandom);
      if (alt.h != alt.l && alt != base && alt != same_bucket[same_bucket.size() - 1] &&
          node_bucket(alt) == want)
        same_bucket.push_back(alt);
    end
    for (int i = 0; i < 3; i++) post_request(same_bucket[i]);
    for (int i = 0; i < 3; i++) post_request(same_bucket[i]);
    wait_until_drained();

    repeat (180) post_request(random_node_request());
    wait_until_drained();

    send_idle_pct = 61;
    recv_stall_pct = 6;
    repeat (90) post_request(random_node_request());
    wait_until_drained();
    repeat (90) post_request(random_node_request());
    wait_until_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (190) post_request(random_node_request());
    wait_until_drained();

    repeat (64) @(posedge clk);
    $display("Checked %0d requests: %0d found, %0d created, %0d reduced, %0d refused as full.",
             accepted_count, status_seen[ST_FOUND], status_seen[ST_NEW],
             status_seen[ST_REDUCED], status_seen[ST_FULL]);
    $display("Store ended with %0d of %0d nodes in use.", nodes_used, TABLE_DEPTH);
    if (error_count == 0) begin
      $display("tb_bdd_unique_node_table_unit: done, clean");
    end else begin
      $display("tb_bdd_unique_node_table_unit: done, errors");
    end
    $finish;
  end

endmodule
